@@ rtl/ecr_pkg.sv @@
// shared types and constants of the edge coverage recorder
`timescale 1ns / 1ps
package ecr_pkg;

	localparam logic [2:0] OP_DIRECT  = 3'd0;
	localparam logic [2:0] OP_RECORD  = 3'd1;
	localparam logic [2:0] OP_COMMIT  = 3'd2;
	localparam logic [2:0] OP_DISCARD = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [63:0] MIX_MULT = 64'h7fb5d329728ea185;
	localparam int MIX_SHIFT = 31;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] source_address;
		logic [63:0] target_address;
	} item_t;

	typedef struct packed {
		logic [15:0] map_index;
		logic [7:0]  new_count;
		logic [7:0]  listed_count;
		logic [31:0] edge_total;
		logic        overflow;
	} result_t;

endpackage

@@ rtl/edge_coverage_recorder_top.sv @@
// top level of the edge coverage recorder
`timescale 1ns / 1ps
// edge coverage recorder
// a transaction is accepted at a clock edge with start high and busy low; item carries
// the opcode and the edge source and target addresses
// every transaction gives one result: result is valid for the single cycle in which
// done is high, and the receiver cannot stall it
// the coverage map and the pending counts each live in a ram of MAP_ENTRIES bytes,
// the list of touched indexes in a ram of MAX_TOUCHED entries
// steps, from accept to done:
//   direct or record edge: hash multiply, ram read, modify and write
//   commit: list walk adding counts into the map, then a second walk
//           zeroing pending counts
//   discard: a walk zeroing pending counts
//   clear map: a sweep writing one map byte per cycle
//   undefined opcodes: done with no other action
// the next transaction is taken the cycle done is high
// after reset the block sweeps the map and pending rams to zero, one entry a cycle,
// with busy high and no result
module edge_coverage_recorder_top #(
	parameter int MAP_ENTRIES = 65536,
	parameter int MAX_TOUCHED = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ecr_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output ecr_pkg::result_t result
);
	localparam int IW = $clog2(MAP_ENTRIES);
	localparam int LW = MAX_TOUCHED > 1 ? $clog2(MAX_TOUCHED) : 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_HASH  = 9'b000000010,
		S_EDGE  = 9'b000000100,
		S_CLST  = 9'b000001000,
		S_CRD   = 9'b000010000,
		S_CWR   = 9'b000100000,
		S_ZLST  = 9'b001000000,
		S_ZWR   = 9'b010000000,
		S_SWEEP = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [2:0]       op_q;
	logic [7:0]       cnt_q;      // listed indexes
	logic [31:0]      edges_q;    // recorded edge total
	logic [7:0]       i_q;        // list walk position
	logic [IW-1:0]    sweep_q;
	logic             rst_sweep_q; // sweep after reset, also clears pending counts
	logic [IW-1:0]    k_q;

	// hash
	logic [IW-1:0] hidx;
	logic          hload;

	// ram ports
	logic          cov_we, pend_we, list_we;
	logic [IW-1:0] cov_waddr, cov_raddr, pend_waddr, pend_raddr;
	logic [7:0]    cov_wdata, cov_rdata, pend_wdata, pend_rdata;
	logic [IW-1:0] list_wdata, list_rdata;
	logic [LW-1:0] list_waddr, list_raddr;

	logic accept;
	logic full;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign hload  = accept;
	assign full   = (cnt_q == 8'(MAX_TOUCHED));

	ecr_hash #(.IW(IW)) u_hash (
		.clk (clk),
		.load(hload),
		.src (item.source_address),
		.dst (item.target_address),
		.idx (hidx)
	);

	ecr_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_cov (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.raddr(cov_raddr), .rdata(cov_rdata)
	);

	ecr_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_pend (
		.clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
		.raddr(pend_raddr), .rdata(pend_rdata)
	);

	ecr_ram #(.WIDTH(IW), .DEPTH(MAX_TOUCHED)) u_list (
		.clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
		.raddr(list_raddr), .rdata(list_rdata)
	);

	// read addresses: the hashed index for edges, the listed index in walks
	always_comb begin
		cov_raddr  = hidx;
		pend_raddr = hidx;
		list_raddr = i_q[LW-1:0];
		if (state_q == S_CRD) begin
			cov_raddr  = list_rdata;
			pend_raddr = list_rdata;
		end
	end

	// writes
	always_comb begin
		cov_we     = 1'b0;
		cov_waddr  = hidx;
		cov_wdata  = cov_rdata + 8'd1;
		pend_we    = 1'b0;
		pend_waddr = hidx;
		pend_wdata = pend_rdata + 8'd1;
		list_we    = 1'b0;
		list_waddr = cnt_q[LW-1:0];
		list_wdata = hidx;
		unique case (state_q)
			S_EDGE: begin
				if (op_q == ecr_pkg::OP_DIRECT) begin
					cov_we = 1'b1;
				end else if (pend_rdata != 8'd0 || !full) begin
					pend_we = 1'b1;
					list_we = (pend_rdata == 8'd0);
				end
			end
			S_CWR: begin
				cov_we    = 1'b1;
				cov_waddr = k_q;
				cov_wdata = cov_rdata + pend_rdata;
			end
			S_ZWR: begin
				pend_we    = 1'b1;
				pend_waddr = list_rdata;
				pend_wdata = 8'd0;
			end
			S_SWEEP: begin
				cov_we     = 1'b1;
				cov_waddr  = sweep_q;
				cov_wdata  = 8'd0;
				pend_we    = rst_sweep_q;
				pend_waddr = sweep_q;
				pend_wdata = 8'd0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			rst_sweep_q <= 1'b1;
			sweep_q     <= '0;
			cnt_q       <= '0;
			edges_q     <= '0;
			i_q         <= '0;
			op_q        <= '0;
			done        <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= item.opcode;
						i_q  <= '0;
						unique case (item.opcode)
							ecr_pkg::OP_DIRECT,
							ecr_pkg::OP_RECORD:  state_q <= S_HASH;
							ecr_pkg::OP_COMMIT:  state_q <= S_CLST;
							ecr_pkg::OP_DISCARD: state_q <= S_ZLST;
							ecr_pkg::OP_CLEAR: begin
								state_q     <= S_SWEEP;
								sweep_q     <= '0;
								rst_sweep_q <= 1'b0;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_HASH: state_q <= S_EDGE;
				S_EDGE: begin
					if (op_q == ecr_pkg::OP_RECORD) begin
						edges_q <= edges_q + 32'd1;
						if (pend_rdata == 8'd0 && !full) begin
							cnt_q <= cnt_q + 8'd1;
						end
					end
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLST: begin
					if (i_q == cnt_q) begin
						i_q     <= '0;
						state_q <= S_ZLST;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					k_q     <= list_rdata;
					state_q <= S_CWR;
				end
				S_CWR: begin
					i_q     <= i_q + 8'd1;
					state_q <= S_CLST;
				end
				S_ZLST: begin
					if (i_q == cnt_q) begin
						cnt_q   <= '0;
						edges_q <= '0;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ZWR;
					end
				end
				S_ZWR: begin
					i_q     <= i_q + 8'd1;
					state_q <= S_ZLST;
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + IW'(1);
					if (sweep_q == IW'(MAP_ENTRIES - 1)) begin
						done        <= !rst_sweep_q;
						rst_sweep_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register, written alongside done
	always_ff @(posedge clk) begin
		if (state_q == S_EDGE) begin
			result.map_index    <= 16'(hidx);
			result.listed_count <= cnt_q;
			result.edge_total   <= edges_q;
			result.overflow     <= 1'b0;
			if (op_q == ecr_pkg::OP_DIRECT) begin
				result.new_count <= cov_rdata + 8'd1;
			end else begin
				result.edge_total <= edges_q + 32'd1;
				if (pend_rdata == 8'd0 && full) begin
					result.new_count <= 8'd0;
					result.overflow  <= 1'b1;
				end else begin
					result.new_count <= pend_rdata + 8'd1;
					if (pend_rdata == 8'd0) begin
						result.listed_count <= cnt_q + 8'd1;
					end
				end
			end
		end else begin
			result.map_index    <= '0;
			result.new_count    <= '0;
			result.overflow     <= 1'b0;
			result.listed_count <= (state_q == S_ZLST) ? 8'd0 : cnt_q;
			result.edge_total   <= (state_q == S_ZLST) ? 32'd0 : edges_q;
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(MAX_TOUCHED)) else $error("list count beyond capacity");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.listed_count == 8'(MAX_TOUCHED))
		else $error("overflow with list not full");
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.opcode == ecr_pkg::OP_CLEAR |=> state_q == S_SWEEP)
		else $error("clear map did not start sweep");
`endif
endmodule

@@ rtl/ecr_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module ecr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/ecr_hash.sv @@
// edge hash: low bits of the two address mixes, registered
`timescale 1ns / 1ps
module ecr_hash #(
	parameter int IW = 16
) (
	input  logic          clk,
	input  logic          load,
	input  logic [63:0]   src,
	input  logic [63:0]   dst,
	output logic [IW-1:0] idx
);
	// only the low IW+1 product bits reach the index
	localparam int HW = IW + 1;
	localparam logic [HW-1:0] MC = HW'(ecr_pkg::MIX_MULT);

	logic [HW-1:0] vs, vd, ps_q, pd_q;

	assign vs = src[HW-1:0] ^ src[HW+ecr_pkg::MIX_SHIFT-1:ecr_pkg::MIX_SHIFT];
	assign vd = dst[HW-1:0] ^ dst[HW+ecr_pkg::MIX_SHIFT-1:ecr_pkg::MIX_SHIFT];

	always_ff @(posedge clk) begin
		if (load) begin
			ps_q <= vs * MC;
			pd_q <= vd * MC;
		end
	end

	assign idx = pd_q[IW-1:0] ^ ps_q[IW:1];
endmodule
